// File: rtl/ipf_pkg.sv
// shared types, constants and filter functions of the isolated pixel filter
package ipf_pkg;

  localparam int CFG_W = 12;
  localparam int DEF_MAX_WIDTH = 2048;
  localparam int DEF_MAX_HEIGHT = 2048;
  localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH = 12'd64;
  localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = 12'd64;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  localparam int PIX_W = 8;
  localparam logic [PIX_W-1:0] PIX_BG = 8'd255;
  localparam logic [PIX_W-1:0] PIX_INK = 8'd0;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam logic [1:0] CLS_BG = 2'd0;
  localparam logic [1:0] CLS_INK = 2'd1;
  localparam logic [1:0] CLS_OTHER = 2'd2;

  localparam int OQ_DEPTH = 8;

  typedef struct packed {
    logic             cmd;
    logic [PIX_W-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             row_end;
    logic             frame_end;
  } out_beat_t;

  // per-item control handed from the position logic to the window stage
  typedef struct packed {
    logic       valid;
    logic       flush;
    logic [1:0] cls;
    logic       emit_a;
    logic       emit_b;
    logic       left_a;
    logic       left_b;
    logic       right_ok;
    logic       top_ok;
  } op_t;

  typedef struct packed {
    logic [1:0] n;
    out_beat_t  b0;
    out_beat_t  b1;
  } push_t;

  function automatic logic [1:0] classify(input logic [PIX_W-1:0] pix);
    logic [1:0] cls;
    if (pix == PIX_BG) begin
      cls = CLS_BG;
    end else if (pix == PIX_INK) begin
      cls = CLS_INK;
    end else begin
      cls = CLS_OTHER;
    end
    return cls;
  endfunction

  // column: [1:0] top, [3:2] middle, [5:4] bottom
  function automatic logic col_ink(input logic [5:0] col, input logic tv, input logic mid,
                                   input logic bv);
    return (tv && col[1:0] == CLS_INK) || (mid && col[3:2] == CLS_INK) ||
           (bv && col[5:4] == CLS_INK);
  endfunction

  // window: [5:0] right column, [11:6] middle, [17:12] left
  function automatic logic [PIX_W-1:0] judge(input logic [17:0] win, input logic cc,
                                             input logic lv, input logic rv,
                                             input logic tv, input logic bv);
    logic [5:0] lcol;
    logic [5:0] ccol;
    logic [5:0] rcol;
    logic       hit;
    lcol = cc ? win[17:12] : win[11:6];
    ccol = cc ? win[11:6] : win[5:0];
    rcol = win[5:0];
    hit = (lv && col_ink(lcol, tv, 1'b1, bv)) || (rv && cc && col_ink(rcol, tv, 1'b1, bv)) ||
          col_ink(ccol, tv, 1'b0, bv);
    return (ccol[3:2] == CLS_BG || !hit) ? PIX_BG : PIX_INK;
  endfunction

endpackage

// File: rtl/ipf_ram.sv
// generic single-write, single-read ram with registered read data
module ipf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/ipf_ctrl.sv
// input position, drain counter and per-item control for the filter
module ipf_ctrl import ipf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int HW = $clog2(MAX_HEIGHT + 1),
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  in_beat_t         beat_i,
  input  logic [CFG_W-1:0] cfg_width_i,
  input  logic [CFG_W-1:0] cfg_height_i,
  output op_t              op_o,
  output logic [AW-1:0]    addr_l_o,
  output logic [AW-1:0]    addr_c_o,
  output logic [AW-1:0]    addr_r_o
);

  localparam int XW = (WW > CFG_W) ? WW : CFG_W;
  localparam int YW = (HW > CFG_W) ? HW : CFG_W;

  logic [WW-1:0] col_q, col_d;
  logic [HW-1:0] row_q, row_d;
  logic [WW-1:0] drain_q, drain_d;

  logic [XW-1:0] w_ext;
  logic [YW-1:0] h_ext;
  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic [WW:0]   c_inc;
  logic [HW:0]   r_inc;
  logic          last_col;
  logic [WW-1:0] dc;
  logic [WW-1:0] d;
  logic [WW:0]   d_inc;
  logic [WW-1:0] d_dec;

  // effective dimensions: zero acts as one, large values saturate
  always_comb begin
    w_ext = XW'(cfg_width_i);
    h_ext = YW'(cfg_height_i);
    if (w_ext == '0) begin
      w_eff = WW'(1);
    end else if (w_ext > XW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(w_ext);
    end
    if (h_ext == '0) begin
      h_eff = HW'(1);
    end else if (h_ext > YW'(MAX_HEIGHT)) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(h_ext);
    end
  end

  always_comb begin
    c_inc = {1'b0, col_q} + (WW+1)'(1);
    r_inc = {1'b0, row_q} + (HW+1)'(1);
    last_col = c_inc >= {1'b0, w_eff};
    dc = (drain_q > w_eff) ? w_eff : drain_q;
    d = w_eff - dc;
    d_inc = {1'b0, d} + (WW+1)'(1);
    d_dec = d - WW'(1);
  end

  always_comb begin
    op_o = '0;
    addr_l_o = col_q[AW-1:0];
    addr_c_o = col_q[AW-1:0];
    addr_r_o = col_q[AW-1:0];
    col_d = col_q;
    row_d = row_q;
    drain_d = drain_q;
    if (accept_i) begin
      if (beat_i.cmd == CMD_FLUSH) begin
        if (drain_q != '0) begin
          op_o.valid = 1'b1;
          op_o.flush = 1'b1;
          op_o.emit_a = 1'b1;
          op_o.left_a = d != '0;
          op_o.right_ok = d_inc < {1'b0, w_eff};
          op_o.top_ok = (h_eff >> 1) != '0;
          addr_l_o = d_dec[AW-1:0];
          addr_c_o = d[AW-1:0];
          addr_r_o = d_inc[AW-1:0];
          drain_d = dc - WW'(1);
        end
      end else begin
        op_o.valid = 1'b1;
        op_o.cls = classify(beat_i.pixel_in);
        op_o.emit_a = (row_q != '0) && (col_q != '0);
        op_o.emit_b = last_col && (row_q != '0);
        op_o.left_a = (col_q >> 1) != '0;
        op_o.left_b = col_q != '0;
        op_o.right_ok = 1'b1;
        op_o.top_ok = (row_q >> 1) != '0;
        drain_d = '0;
        if (last_col) begin
          col_d = '0;
          if (r_inc >= {1'b0, h_eff}) begin
            row_d = '0;
            drain_d = w_eff;
          end else begin
            row_d = r_inc[HW-1:0];
          end
        end else begin
          col_d = c_inc[WW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      drain_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      drain_q <= drain_d;
    end
  end

endmodule

// File: rtl/ipf_core.sv
// line stores, write-back forwarding, 3x3 window and filter decision
module ipf_core import ipf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  op_t           op_i,
  input  logic [AW-1:0] addr_l_i,
  input  logic [AW-1:0] addr_c_i,
  input  logic [AW-1:0] addr_r_i,
  output push_t         push_o
);

  op_t           op_q;
  logic [AW-1:0] raddr_l_q;
  logic [AW-1:0] raddr_c_q;
  logic [AW-1:0] raddr_r_q;
  logic          pw_valid_q;
  logic [AW-1:0] pw_addr_q;
  logic [3:0]    pw_data_q;
  logic [17:0]   window_q, window_d;

  logic [3:0]  rdata_l, rdata_c, rdata_r;
  logic [3:0]  mem_l, mem_c, mem_r;
  logic        wr_en;
  logic [3:0]  wr_data;
  logic [5:0]  pix_col;
  logic [17:0] win_next;
  logic [17:0] fwin;
  logic [PIX_W-1:0] res_a, res_b, res_f;

  // each copy holds {older, newer} classes of one column
  ipf_ram #(.WIDTH(4), .DEPTH(MAX_WIDTH)) u_ram_l (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(raddr_c_q),
    .wdata_i(wr_data),
    .raddr_i(addr_l_i),
    .rdata_o(rdata_l)
  );

  ipf_ram #(.WIDTH(4), .DEPTH(MAX_WIDTH)) u_ram_c (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(raddr_c_q),
    .wdata_i(wr_data),
    .raddr_i(addr_c_i),
    .rdata_o(rdata_c)
  );

  ipf_ram #(.WIDTH(4), .DEPTH(MAX_WIDTH)) u_ram_r (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(raddr_c_q),
    .wdata_i(wr_data),
    .raddr_i(addr_r_i),
    .rdata_o(rdata_r)
  );

  // write at the edge of the read returns old data, so take the written value
  always_comb begin
    mem_l = (pw_valid_q && pw_addr_q == raddr_l_q) ? pw_data_q : rdata_l;
    mem_c = (pw_valid_q && pw_addr_q == raddr_c_q) ? pw_data_q : rdata_c;
    mem_r = (pw_valid_q && pw_addr_q == raddr_r_q) ? pw_data_q : rdata_r;
  end

  always_comb begin
    wr_en = op_q.valid && !op_q.flush;
    wr_data = {mem_c[1:0], op_q.cls};
    pix_col = {op_q.cls, mem_c[1:0], mem_c[3:2]};
    win_next = {window_q[11:0], pix_col};
    window_d = wr_en ? win_next : window_q;
    fwin[17:12] = op_q.left_a ? {2'b00, mem_l[1:0], mem_l[3:2]} : 6'd0;
    fwin[11:6] = {2'b00, mem_c[1:0], mem_c[3:2]};
    fwin[5:0] = op_q.right_ok ? {2'b00, mem_r[1:0], mem_r[3:2]} : 6'd0;
    res_a = judge(win_next, 1'b1, op_q.left_a, 1'b1, op_q.top_ok, 1'b1);
    res_b = judge(win_next, 1'b0, op_q.left_b, 1'b0, op_q.top_ok, 1'b1);
    res_f = judge(fwin, 1'b1, op_q.left_a, op_q.right_ok, op_q.top_ok, 1'b0);
  end

  always_comb begin
    push_o = '0;
    if (op_q.valid) begin
      if (op_q.flush) begin
        push_o.n = 2'd1;
        push_o.b0 = '{pixel_out: res_f, row_end: !op_q.right_ok, frame_end: !op_q.right_ok};
      end else begin
        push_o.n = 2'({1'b0, op_q.emit_a} + {1'b0, op_q.emit_b});
        push_o.b0 = op_q.emit_a ? '{pixel_out: res_a, row_end: 1'b0, frame_end: 1'b0}
                                : '{pixel_out: res_b, row_end: 1'b1, frame_end: 1'b0};
        push_o.b1 = '{pixel_out: res_b, row_end: 1'b1, frame_end: 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= '0;
      pw_valid_q <= 1'b0;
      window_q <= '0;
    end else begin
      op_q <= op_i;
      pw_valid_q <= wr_en;
      window_q <= window_d;
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_l_q <= addr_l_i;
    raddr_c_q <= addr_c_i;
    raddr_r_q <= addr_r_i;
    pw_addr_q <= raddr_c_q;
    pw_data_q <= wr_data;
  end

endmodule

// File: rtl/ipf_outq.sv
// result queue taking up to two beats per cycle, one beat out per cycle while out_ready_i is high
module ipf_outq import ipf_pkg::*; #(
  parameter int DEPTH = OQ_DEPTH,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      room_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_beat_t out_data_o
);

  out_beat_t     fifo_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PW-1:0] wr_ptr_nx;
  logic          pop;

  always_comb begin
    pop = out_valid_o && out_ready_i;
    wr_ptr_nx = wr_ptr_q + PW'(1);
    cnt_d = cnt_q + CW'(push_i.n) - CW'(pop);
    // room for the beats of the item in the window stage plus two more
    room_o = ({1'b0, cnt_q} + (CW+1)'(push_i.n) + (CW+1)'(2)) <= (CW+1)'(DEPTH);
  end

  assign out_valid_o = cnt_q != '0;
  assign out_data_o = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.n != 2'd0) begin
      fifo_q[wr_ptr_q] <= push_i.b0;
    end
    if (push_i.n == 2'd2) begin
      fifo_q[wr_ptr_nx] <= push_i.b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(push_i.n);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      cnt_q <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cnt_q} + (CW+1)'(push_i.n)) <= (CW+1)'(DEPTH))
    else $error("result queue overflow");

endmodule

// File: rtl/isolated_pixel_filter.sv
// top level: 3x3 isolated pixel removal over a raster pixel stream
// throughput: one item per cycle while the result queue has room; the line store does one read-modify-write per pixel
// an accepted item is registered into the window stage, and its result beats are then written into the result queue
// a pixel gives up to two beats, a flush at most one; input stalls while the result queue lacks room
// reset clears position, drain count, window and queue; line stores are not cleared
module isolated_pixel_filter import ipf_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_beat_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic [CFG_W-1:0] width_q;
  logic [CFG_W-1:0] height_q;
  logic             cfg_wr;
  logic             accept;
  logic             room;
  op_t              op;
  push_t            push;
  logic [AW-1:0]    addr_l, addr_c, addr_r;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH: prdata = APB_DW'(width_q);
      REG_IMAGE_HEIGHT: prdata = APB_DW'(height_q);
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= RST_IMAGE_WIDTH;
      height_q <= RST_IMAGE_HEIGHT;
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_IMAGE_WIDTH: width_q <= pwdata[CFG_W-1:0];
        REG_IMAGE_HEIGHT: height_q <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = room;
  assign accept = in_valid_i && in_ready_o;

  ipf_ctrl #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .beat_i      (in_data_i),
    .cfg_width_i (width_q),
    .cfg_height_i(height_q),
    .op_o        (op),
    .addr_l_o    (addr_l),
    .addr_c_o    (addr_c),
    .addr_r_o    (addr_r)
  );

  ipf_core #(.MAX_WIDTH(MAX_WIDTH)) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (op),
    .addr_l_i(addr_l),
    .addr_c_i(addr_c),
    .addr_r_i(addr_r),
    .push_o  (push)
  );

  ipf_outq #(.DEPTH(OQ_DEPTH)) u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room_o     (room),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  a_frame_has_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.frame_end |-> out_data_o.row_end)
    else $error("frame end beat without row end");

  a_bilevel_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pixel_out == PIX_BG || out_data_o.pixel_out == PIX_INK))
    else $error("output pixel not bilevel");

endmodule
